// ===== rtl/stl_pkg.sv =====
// Shared types, constants and helper functions for the script token lexer.
// No dependencies; every other file of the block except stl_if imports this package.
`default_nettype none

package stl_pkg;

  // Sizing.
  localparam int KeywordMax   = 8;
  localparam int OffsetBits   = 16;
  localparam int WordLenBits  = $clog2(KeywordMax + 2);
  localparam int WordIdxBits  = $clog2(KeywordMax);
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);
  localparam int NumKeywords  = 9;

  // Lexer modes.
  localparam logic [3:0] ModeIdle      = 4'd0;
  localparam logic [3:0] ModeSlash     = 4'd1;
  localparam logic [3:0] ModeLineC     = 4'd2;
  localparam logic [3:0] ModeBlock     = 4'd3;
  localparam logic [3:0] ModeBlockStar = 4'd4;
  localparam logic [3:0] ModeOp        = 4'd5;
  localparam logic [3:0] ModeId        = 4'd6;
  localparam logic [3:0] ModeInt       = 4'd7;
  localparam logic [3:0] ModeFloat     = 4'd8;
  localparam logic [3:0] ModeStr       = 4'd9;
  localparam logic [3:0] ModeStrEsc    = 4'd10;

  // Token kinds.
  localparam logic [4:0] KindText       = 5'd0;
  localparam logic [4:0] KindEof        = 5'd0;
  localparam logic [4:0] KindId         = 5'd1;
  localparam logic [4:0] KindInt        = 5'd2;
  localparam logic [4:0] KindFloat      = 5'd3;
  localparam logic [4:0] KindStr        = 5'd4;
  localparam logic [4:0] KindEqEq       = 5'd5;
  localparam logic [4:0] KindNotEq      = 5'd6;
  localparam logic [4:0] KindLessEq     = 5'd7;
  localparam logic [4:0] KindGreaterEq  = 5'd8;
  localparam logic [4:0] KindPlusEq     = 5'd9;
  localparam logic [4:0] KindMinusEq    = 5'd10;
  localparam logic [4:0] KindPlusPlus   = 5'd11;
  localparam logic [4:0] KindMinusMinus = 5'd12;
  localparam logic [4:0] KindAndAnd     = 5'd13;
  localparam logic [4:0] KindOrOr       = 5'd14;
  localparam logic [4:0] KindKw0        = 5'd15;
  localparam logic [4:0] KindSingle     = 5'd24;

  // Characters with a special role.
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChEq        = 8'h3D;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChLess      = 8'h3C;
  localparam logic [7:0] ChGreater   = 8'h3E;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChBar       = 8'h7C;

  // Keywords, right aligned: the first character sits in the highest used byte.
  localparam logic [63:0] KwText [NumKeywords] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("for"), 64'("function"),
    64'("return"), 64'("var"), 64'("true"), 64'("false")
  };
  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd8, 4'd6, 4'd3, 4'd4, 4'd5
  };

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  text;
    logic        has;
    logic        last;
    logic [15:0] start;
  } tok_t;

  // All results of one input item; r1 is valid when two is set.
  typedef struct packed {
    logic two;
    tok_t r1;
    tok_t r0;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic tok_t mk_tok(logic [4:0] kind, logic [7:0] text, logic has,
                                  logic last, logic [15:0] start);
    tok_t t;
    t.kind  = kind;
    t.text  = has ? text : 8'd0;
    t.has   = has;
    t.last  = last;
    t.start = start;
    return t;
  endfunction

  function automatic logic [15:0] off_to16(logic [OffsetBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return c == ChEq || c == ChBang || c == ChLess || c == ChGreater ||
           c == ChPlus || c == ChMinus || c == ChAmp || c == ChBar;
  endfunction

  // Kind of a two-character operator, or KindText when the pair is none.
  function automatic logic [4:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [4:0] k;
    k = KindText;
    if (b == ChEq) begin
      case (a)
        ChEq:      k = KindEqEq;
        ChBang:    k = KindNotEq;
        ChLess:    k = KindLessEq;
        ChGreater: k = KindGreaterEq;
        ChPlus:    k = KindPlusEq;
        ChMinus:   k = KindMinusEq;
        default:   k = KindText;
      endcase
    end
    if (a == ChPlus && b == ChPlus) k = KindPlusPlus;
    if (a == ChMinus && b == ChMinus) k = KindMinusMinus;
    if (a == ChAmp && b == ChAmp) k = KindAndAnd;
    if (a == ChBar && b == ChBar) k = KindOrOr;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stl_if.sv =====
// Valid/ready channel interfaces of the script token lexer.
// Depends on nothing; the payload follows the item fields of the block.
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [7:0]  text_char;
  logic        has_char;
  logic        token_end;
  logic [15:0] start_offset;

  modport source (output valid, output token_kind, output text_char, output has_char,
                  output token_end, output start_offset, input ready);
  modport sink (input valid, input token_kind, input text_char, input has_char,
                input token_end, input start_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/script_token_lexer_unit.sv =====
// Top level of the script token lexer: front end, bundle queue and back end.
// Depends on stl_pkg, stl_if, stl_front, stl_queue and stl_back.
//
// The block takes script text on in_i, one byte per item, and streams tokens
// on out_o. An item with end_of_text set closes any open token, emits an EOF
// item carrying the byte count, and restarts the offset at zero for new text.
// Identifier, number and string text is streamed one character per item with
// token_end low; the item with token_end high carries the token kind.
//
// Throughput: one input item per cycle while the queue is not full. A byte causes
// zero, one or two result items; the output register delivers one result item per
// cycle while the receiver is ready, so a run of bytes that each cause two results
// is limited by the output side.
// Path: a byte's results are written to the queue when the byte is accepted, and
// the output register then loads them from the queue head, one item at a time.
//
// The front end evaluates the lexer state machine for each accepted byte and
// pushes that byte's results as one bundle into a four-entry queue. The back
// end splits bundles into single items. When the receiver stalls, the queue
// absorbs up to four bundles before in_i.ready drops; nothing is lost.
// After reset the lexer is between tokens, the offset is zero and the block
// is ready at once.
`default_nettype none

module script_token_lexer_unit import stl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_in_if.sink    in_i,
  stl_out_if.source out_o
);

  logic    push;
  logic    pop;
  bundle_t push_bundle;
  bundle_t head_bundle;
  q_stat_t q_stat;

  // Front end: lexer state, lookahead byte and keyword buffer.
  stl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  // Decoupling queue: one entry per byte that produced results.
  stl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .stat_o      (q_stat)
  );

  // Back end: serializes bundles into the output register.
  stl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_bundle),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/stl_front.sv =====
// Lexer front end: accepts bytes, runs the lexer state machine and pushes the
// results of each byte as one bundle. Depends on stl_pkg and stl_if.
`default_nettype none

module stl_front import stl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  stl_in_if.sink  in_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output bundle_t bundle_o
);

  logic [3:0]                 mode_q, mode_d;
  logic [7:0]                 held_q, held_d;
  logic [KeywordMax-1:0][7:0] wbuf_q;
  logic [WordLenBits-1:0]     wlen_q, wlen_d;
  logic [OffsetBits-1:0]      offset_q, offset_d;
  logic [OffsetBits-1:0]      tstart_q, tstart_d;

  logic                   accept;
  logic                   wb_we;
  logic [WordIdxBits-1:0] wb_idx;
  logic [7:0]             c;
  logic [4:0]             pk;
  logic [4:0]             wkind;
  logic [15:0]            ts16;
  logic [15:0]            off16;
  logic                   idle_path;
  logic [1:0]             cnt;
  tok_t                   res [2];

  // Keyword lookup over the buffered first characters of a word.
  function automatic logic [4:0] word_kind(logic [KeywordMax-1:0][7:0] wbuf,
                                           logic [WordLenBits-1:0] len);
    logic [4:0] k;
    logic       hit;
    k = KindId;
    for (int i = 0; i < NumKeywords; i++) begin
      hit = (len == WordLenBits'(KwLen[i]));
      for (int j = 0; j < 8; j++) begin
        if (j < int'(KwLen[i])) begin
          if (wbuf[j] != KwText[i][(int'(KwLen[i]) - 1 - j) * 8 +: 8]) hit = 1'b0;
        end
      end
      if (hit) k = KindKw0 + 5'(i);
    end
    return k;
  endfunction

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.ch;
  assign pk         = pair_kind(held_q, c);
  assign wkind      = word_kind(wbuf_q, wlen_q);
  assign ts16       = off_to16(tstart_q);
  assign off16      = off_to16(offset_q);

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    wlen_d    = wlen_q;
    offset_d  = offset_q;
    tstart_d  = tstart_q;
    wb_we     = 1'b0;
    wb_idx    = '0;
    idle_path = 1'b0;
    cnt       = 2'd0;
    res[0]    = '0;
    res[1]    = '0;

    if (in_i.end_of_text) begin
      // Close any open token, then report the end with the byte count.
      case (mode_q)
        ModeSlash, ModeOp: begin
          res[cnt[0]] = mk_tok(KindSingle, held_q, 1'b1, 1'b1, ts16);
          cnt = cnt + 2'd1;
        end
        ModeId: begin
          res[cnt[0]] = mk_tok(wkind, 8'd0, 1'b0, 1'b1, ts16);
          cnt = cnt + 2'd1;
        end
        ModeInt: begin
          res[cnt[0]] = mk_tok(KindInt, 8'd0, 1'b0, 1'b1, ts16);
          cnt = cnt + 2'd1;
        end
        ModeFloat: begin
          res[cnt[0]] = mk_tok(KindFloat, 8'd0, 1'b0, 1'b1, ts16);
          cnt = cnt + 2'd1;
        end
        ModeStr, ModeStrEsc: begin
          res[cnt[0]] = mk_tok(KindStr, 8'd0, 1'b0, 1'b1, ts16);
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      res[cnt[0]] = mk_tok(KindEof, 8'd0, 1'b0, 1'b1, off16);
      cnt      = cnt + 2'd1;
      mode_d   = ModeIdle;
      held_d   = 8'd0;
      wlen_d   = '0;
      offset_d = '0;
      tstart_d = '0;
    end else begin
      offset_d = offset_q + OffsetBits'(1);
      case (mode_q)
        ModeSlash: begin
          if (c == ChSlash) begin
            mode_d = ModeLineC;
          end else if (c == ChStar) begin
            mode_d = ModeBlockStar;
          end else begin
            res[cnt[0]] = mk_tok(KindSingle, held_q, 1'b1, 1'b1, ts16);
            cnt = cnt + 2'd1;
            idle_path = 1'b1;
          end
        end
        ModeLineC: begin
          if (c == ChLf) mode_d = ModeIdle;
        end
        ModeBlock: begin
          if (c == ChStar) mode_d = ModeBlockStar;
        end
        ModeBlockStar: begin
          if (c == ChSlash) mode_d = ModeIdle;
          else if (c != ChStar) mode_d = ModeBlock;
        end
        ModeOp: begin
          if (pk != KindText) begin
            res[cnt[0]] = mk_tok(pk, 8'd0, 1'b0, 1'b1, ts16);
            cnt = cnt + 2'd1;
            mode_d = ModeIdle;
          end else begin
            res[cnt[0]] = mk_tok(KindSingle, held_q, 1'b1, 1'b1, ts16);
            cnt = cnt + 2'd1;
            idle_path = 1'b1;
          end
        end
        ModeId: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (wlen_q < WordLenBits'(KeywordMax)) begin
              wb_we  = 1'b1;
              wb_idx = wlen_q[WordIdxBits-1:0];
            end
            if (wlen_q <= WordLenBits'(KeywordMax)) wlen_d = wlen_q + WordLenBits'(1);
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, ts16);
            cnt = cnt + 2'd1;
          end else begin
            res[cnt[0]] = mk_tok(wkind, 8'd0, 1'b0, 1'b1, ts16);
            cnt = cnt + 2'd1;
            idle_path = 1'b1;
          end
        end
        ModeInt: begin
          if (is_digit(c) || c == ChDot) begin
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, ts16);
            cnt = cnt + 2'd1;
            if (c == ChDot) mode_d = ModeFloat;
          end else begin
            res[cnt[0]] = mk_tok(KindInt, 8'd0, 1'b0, 1'b1, ts16);
            cnt = cnt + 2'd1;
            idle_path = 1'b1;
          end
        end
        ModeFloat: begin
          if (is_digit(c)) begin
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, ts16);
            cnt = cnt + 2'd1;
          end else begin
            res[cnt[0]] = mk_tok(KindFloat, 8'd0, 1'b0, 1'b1, ts16);
            cnt = cnt + 2'd1;
            idle_path = 1'b1;
          end
        end
        ModeStr: begin
          if (c == ChQuote) begin
            res[cnt[0]] = mk_tok(KindStr, 8'd0, 1'b0, 1'b1, ts16);
            cnt = cnt + 2'd1;
            mode_d = ModeIdle;
          end else if (c == ChBackslash) begin
            mode_d = ModeStrEsc;
          end else begin
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, ts16);
            cnt = cnt + 2'd1;
          end
        end
        ModeStrEsc: begin
          res[cnt[0]] = mk_tok(KindText, (c == ChLowerN) ? ChLf : c, 1'b1, 1'b0, ts16);
          cnt = cnt + 2'd1;
          mode_d = ModeStr;
        end
        default: idle_path = 1'b1;
      endcase

      // Start of a new token from the between-tokens state.
      if (idle_path) begin
        mode_d = ModeIdle;
        if (!is_space(c)) begin
          tstart_d = offset_q;
          if (c == ChSlash) begin
            held_d = c;
            mode_d = ModeSlash;
          end else if (is_op_start(c)) begin
            held_d = c;
            mode_d = ModeOp;
          end else if (is_alpha(c)) begin
            wlen_d = WordLenBits'(1);
            wb_we  = 1'b1;
            wb_idx = '0;
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, off16);
            cnt = cnt + 2'd1;
            mode_d = ModeId;
          end else if (is_digit(c)) begin
            res[cnt[0]] = mk_tok(KindText, c, 1'b1, 1'b0, off16);
            cnt = cnt + 2'd1;
            mode_d = ModeInt;
          end else if (c == ChQuote) begin
            mode_d = ModeStr;
          end else begin
            res[cnt[0]] = mk_tok(KindSingle, c, 1'b1, 1'b1, off16);
            cnt = cnt + 2'd1;
          end
        end
      end
    end
  end

  assign push_o       = accept && (cnt != 2'd0);
  assign bundle_o.two = cnt[1];
  assign bundle_o.r0  = res[0];
  assign bundle_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      held_q   <= 8'd0;
      wlen_q   <= '0;
      offset_q <= '0;
      tstart_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      wlen_q   <= wlen_d;
      offset_q <= offset_d;
      tstart_q <= tstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wb_we) wbuf_q[wb_idx] <= c;
  end

endmodule

`default_nettype wire

// ===== rtl/stl_queue.sv =====
// Short queue of result bundles between the lexer front end and back end.
// Depends on stl_pkg.
`default_nettype none

module stl_queue import stl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output q_stat_t stat_o
);

  bundle_t                  mem [QueueDepth];
  logic [QueuePtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0]  count_q;
  logic                     do_push, do_pop;

  function automatic logic [QueuePtrBits-1:0] ptr_inc(logic [QueuePtrBits-1:0] p);
    return (p == QueuePtrBits'(QueueDepth - 1)) ? '0 : p + QueuePtrBits'(1);
  endfunction

  assign stat_o.full  = (count_q == QueueCntBits'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + QueueCntBits'(1);
      else if (do_pop && !do_push) count_q <= count_q - QueueCntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/stl_back.sv =====
// Lexer back end: splits each queued bundle into single result items and
// holds them in the output register. Depends on stl_pkg and stl_if.
`default_nettype none

module stl_back import stl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  stl_out_if.source out_o
);

  logic ovalid_q;
  logic sub_q;
  tok_t otok_q;
  logic load;
  logic last_sub;

  assign load     = !q_stat_i.empty && (!ovalid_q || out_o.ready);
  assign last_sub = sub_q || !head_i.two;
  assign pop_o    = load && last_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      sub_q    <= 1'b0;
    end else begin
      if (load) begin
        ovalid_q <= 1'b1;
        sub_q    <= !last_sub;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) otok_q <= sub_q ? head_i.r1 : head_i.r0;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.token_kind   = otok_q.kind;
  assign out_o.text_char    = otok_q.text;
  assign out_o.has_char     = otok_q.has;
  assign out_o.token_end    = otok_q.last;
  assign out_o.start_offset = otok_q.start;

endmodule

`default_nettype wire

// ===== rtl/stl_checker.sv =====
// Port-level checks on the token output of the script token lexer, with the
// bind that attaches them to the top level. Depends on stl_pkg.
`default_nettype none

module stl_checker import stl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_i,
  input logic [7:0]  text_char_i,
  input logic        has_char_i,
  input logic        token_end_i,
  input logic [15:0] start_offset_i
);

  // A stalled item keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({token_kind_i, text_char_i, has_char_i, token_end_i, start_offset_i}))
    else $error("stalled token item changed");

  // Without a character the text byte is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_char_i |-> text_char_i == 8'd0)
    else $error("text byte set without a character");

  // Text items carry a character and no kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !token_end_i |-> has_char_i && token_kind_i == KindText)
    else $error("text item malformed");

  // The only closing item that carries a character is a single-character token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_end_i && has_char_i |-> token_kind_i == KindSingle)
    else $error("closing item with character is not a single-character token");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .text_char_i    (out_o.text_char),
  .has_char_i     (out_o.has_char),
  .token_end_i    (out_o.token_end),
  .start_offset_i (out_o.start_offset)
);

`default_nettype wire
